FILE: sv/qwt_pkg.sv
// Shared constants, types and helpers for the quoted word tokenizer.
`timescale 1ns / 1ps
package qwt_pkg;

  // Lexer modes
  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_ESC    = 3'd1;
  localparam logic [2:0] MODE_DQ     = 3'd2;
  localparam logic [2:0] MODE_DQ_ESC = 3'd3;
  localparam logic [2:0] MODE_SQ     = 3'd4;
  localparam logic [2:0] MODE_HALT   = 3'd5;

  // Result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_TOKEN = 2'd1;
  localparam logic [1:0] KIND_LINE  = 2'd2;

  // Characters of interest
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_SQUOT = 8'h27;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam int          CNT_W   = 16;
  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  // Results one input byte can cause; bit 0 token byte, bit 1 token end, bit 2 line done
  typedef struct packed {
    logic [2:0]       valid;
    logic [7:0]       data_byte;
    logic [CNT_W-1:0] byte_total;
    logic [CNT_W-1:0] tok_total;
    logic [CNT_W-1:0] line_total;
  } qwt_bundle_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 16'd1;
  endfunction

endpackage

FILE: sv/qwt_if.sv
// Valid/ready channel interfaces for input bytes and result items.
`timescale 1ns / 1ps
interface qwt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_line;

  modport source (output valid, output ch, output end_of_line, input ready);
  modport sink   (input valid, input ch, input end_of_line, output ready);
endinterface

interface qwt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [15:0] token_total;
  logic        run_last;

  modport source (output valid, output kind, output data_byte, output token_total,
                  output run_last, input ready);
  modport sink   (input valid, input kind, input data_byte, input token_total,
                  input run_last, output ready);
endinterface

FILE: sv/qwt_lexer.sv
// Lexer state and per-byte decode into a bundle of up to three results.
`timescale 1ns / 1ps
module qwt_lexer (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          ch,
  input  logic                end_of_line,
  output qwt_pkg::qwt_bundle_t bundle
);
  import qwt_pkg::*;

  logic [2:0]       lex_mode, lex_mode_next;
  logic             force_token, force_token_next;
  logic             token_pending, token_pending_next;
  logic [CNT_W-1:0] token_counter, token_counter_next;

  logic [2:0]       mode_n;
  logic             force_n, pend_n, emit, fin, fin_eol;
  logic [CNT_W-1:0] cnt1, cnt2;

  always_comb begin
    mode_n  = lex_mode;
    force_n = force_token;
    pend_n  = token_pending;
    emit    = 1'b0;
    fin     = 1'b0;
    case (lex_mode)
      MODE_NORMAL: begin
        if (ch == CH_NUL) begin
          mode_n = MODE_HALT;
        end else if (ch == CH_BSL) begin
          mode_n = MODE_ESC;
        end else if (ch == CH_DQUOT) begin
          force_n = 1'b1;
          mode_n  = MODE_DQ;
        end else if (ch == CH_SQUOT) begin
          force_n = 1'b1;
          mode_n  = MODE_SQ;
        end else if (ch inside {CH_SPACE, CH_TAB, CH_LF, CH_CR}) begin
          fin = force_token | token_pending;
        end else begin
          emit = 1'b1;
        end
      end
      MODE_ESC: begin
        emit   = 1'b1;
        mode_n = MODE_NORMAL;
      end
      MODE_DQ: begin
        if (ch == CH_NUL) begin
          mode_n = MODE_HALT;
        end else if (ch == CH_BSL) begin
          mode_n = MODE_DQ_ESC;
        end else if (ch == CH_DQUOT) begin
          mode_n = MODE_NORMAL;
        end else begin
          emit = 1'b1;
        end
      end
      MODE_DQ_ESC: begin
        emit   = 1'b1;
        mode_n = MODE_DQ;
      end
      MODE_SQ: begin
        if (ch == CH_NUL) begin
          mode_n = MODE_HALT;
        end else if (ch == CH_SQUOT) begin
          mode_n = MODE_NORMAL;
        end else begin
          emit = 1'b1;
        end
      end
      default: begin
        mode_n = MODE_HALT;
      end
    endcase

    if (emit) begin
      pend_n = 1'b1;
    end
    if (fin) begin
      force_n = 1'b0;
      pend_n  = 1'b0;
    end
    cnt1 = fin ? sat_inc(token_counter) : token_counter;
    // end of line flushes whatever token is still open
    fin_eol = end_of_line & (force_n | pend_n);
    cnt2    = fin_eol ? sat_inc(cnt1) : cnt1;

    bundle.valid      = {end_of_line, fin | fin_eol, emit};
    bundle.data_byte  = ch;
    bundle.byte_total = token_counter;
    bundle.tok_total  = cnt2;
    bundle.line_total = cnt2;

    if (end_of_line) begin
      lex_mode_next      = MODE_NORMAL;
      force_token_next   = 1'b0;
      token_pending_next = 1'b0;
      token_counter_next = '0;
    end else begin
      lex_mode_next      = mode_n;
      force_token_next   = force_n;
      token_pending_next = pend_n;
      token_counter_next = cnt2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode      <= MODE_NORMAL;
      force_token   <= 1'b0;
      token_pending <= 1'b0;
      token_counter <= '0;
    end else if (accept) begin
      lex_mode      <= lex_mode_next;
      force_token   <= force_token_next;
      token_pending <= token_pending_next;
      token_counter <= token_counter_next;
    end
  end

endmodule

FILE: sv/qwt_serializer.sv
// Result register: holds one bundle and hands its results out one per transaction.
`timescale 1ns / 1ps
module qwt_serializer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  qwt_pkg::qwt_bundle_t bundle,
  output logic                 can_load,
  qwt_out_if.source            out_chan
);
  import qwt_pkg::*;

  logic [2:0]  pend, pend_next;
  qwt_bundle_t held;
  logic [2:0]  lowest, rest;
  logic        take;

  always_comb begin
    if (pend[0]) begin
      lowest = 3'b001;
    end else if (pend[1]) begin
      lowest = 3'b010;
    end else begin
      lowest = 3'b100;
    end
    rest = pend & ~lowest;
    take = (|pend) & out_chan.ready;

    out_chan.valid    = |pend;
    out_chan.run_last = (rest == 3'b000);
    if (pend[0]) begin
      out_chan.kind        = KIND_BYTE;
      out_chan.data_byte   = held.data_byte;
      out_chan.token_total = held.byte_total;
    end else if (pend[1]) begin
      out_chan.kind        = KIND_TOKEN;
      out_chan.data_byte   = 8'd0;
      out_chan.token_total = held.tok_total;
    end else begin
      out_chan.kind        = KIND_LINE;
      out_chan.data_byte   = 8'd0;
      out_chan.token_total = held.line_total;
    end

    // a new bundle may enter as the last pending result leaves
    can_load  = (pend == 3'b000) || (take && rest == 3'b000);
    pend_next = take ? rest : pend;
    if (load) begin
      pend_next = bundle.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 3'b000;
    end else begin
      pend <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= bundle;
    end
  end

endmodule

FILE: sv/quoted_word_tokenizer_top.sv
// Top level of the quoted word tokenizer.
// Splits a line, one byte per input transaction, into shell-style words and emits token
// bytes, token-end marks and a line-done item with the saturating token count. A byte
// that causes at most one result is taken every cycle while the output accepts; one that
// causes two or three results holds the input while the output register delivers them,
// one result per output transaction. Bytes with no result leave the result register
// empty. The lexer state and the single result register set this behaviour.
`timescale 1ns / 1ps
module quoted_word_tokenizer_top (
  input  logic       clk,
  input  logic       rst,
  qwt_in_if.sink     in_chan,
  qwt_out_if.source  out_chan
);
  import qwt_pkg::*;

  qwt_bundle_t bundle;
  logic        can_load;
  logic        accept;

  assign in_chan.ready = can_load;
  assign accept        = in_chan.valid & can_load;

  qwt_lexer u_lexer (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .ch          (in_chan.ch),
    .end_of_line (in_chan.end_of_line),
    .bundle      (bundle)
  );

  qwt_serializer u_ser (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .bundle   (bundle),
    .can_load (can_load),
    .out_chan (out_chan)
  );

  a_eol_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && in_chan.end_of_line |=> out_chan.valid)
    else $error("line end accepted without a pending result");

  a_line_is_last: assert property (@(posedge clk) disable iff (rst)
    out_chan.valid && out_chan.kind == KIND_LINE |-> out_chan.run_last)
    else $error("line done item not marked last");

  a_mark_no_data: assert property (@(posedge clk) disable iff (rst)
    out_chan.valid && out_chan.kind != KIND_BYTE |-> out_chan.data_byte == 8'd0)
    else $error("non-byte result carries data");

endmodule
